/* hdl/mpfb_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the page frame store.
package mpfb_pkg;

  // Geometry of the frame store
  localparam int COLUMNS     = 128;
  localparam int PAGES       = 8;
  localparam int HEIGHT      = PAGES * 8;
  localparam int STORE_BYTES = PAGES * COLUMNS;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  // Field widths
  localparam int OP_W    = 2;
  localparam int COORD_W = 8;
  localparam int WB_W    = 5;
  localparam int HR_W    = 7;
  localparam int IDX_W   = 10;
  localparam int BYTE_W  = 8;
  localparam int PSEL_W  = 3;
  localparam int BIT_W   = 3;

  // Width used for bounds checks and address arithmetic
  localparam int CHK_W     = 14;
  localparam int DIV_CNT_W = $clog2(IDX_W);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_PIXEL = 2'd1,
    OP_BLIT  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Commands from the controller
  typedef struct packed {
    logic load;
    logic check;
    logic div_start;
    logic base_load;
    logic rd_en;
    logic rd_next;
    logic rmw_wr;
    logic k_inc;
    logic clr_wr;
  } cmd_t;

  // Status back to the controller
  typedef struct packed {
    op_t  op;
    logic reject;
    logic div_done;
    logic sweep_last;
    logic rmw_last;
  } stat_t;

endpackage

/* hdl/mono_page_framebuffer_blit_unit.sv */
// Top level: monochrome page frame store with clear, pixel, bitmap-byte and read commands.
// From accepted beat to done: set pixel reads and rewrites one byte, read reads one byte,
// blit byte runs the divider, then one memory read-modify-write per column, and clear
// writes one byte per cycle. One command at a time: busy is high through the done cycle,
// so a new command is taken only after the last is done; done is high for a single cycle
// and cannot be stalled. After rst the store is zeroed by a full pass with busy high.
module mono_page_framebuffer_blit_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  output logic                         done,
  input  logic [mpfb_pkg::OP_W-1:0]    operation,
  input  logic [mpfb_pkg::COORD_W-1:0] column,
  input  logic [mpfb_pkg::COORD_W-1:0] row,
  input  logic                         pixel_value,
  input  logic [mpfb_pkg::WB_W-1:0]    width_bytes,
  input  logic [mpfb_pkg::HR_W-1:0]    height_rows,
  input  logic [mpfb_pkg::IDX_W-1:0]   byte_index,
  input  logic [mpfb_pkg::BYTE_W-1:0]  data_byte,
  input  logic [mpfb_pkg::PSEL_W-1:0]  page_select,
  output logic [mpfb_pkg::BYTE_W-1:0]  read_data,
  output logic                         status
);

  mpfb_pkg::cmd_t  cmd;
  mpfb_pkg::stat_t stat;

  // Sequencer
  mpfb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Store and arithmetic
  mpfb_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .operation   (operation),
    .column      (column),
    .row         (row),
    .pixel_value (pixel_value),
    .width_bytes (width_bytes),
    .height_rows (height_rows),
    .byte_index  (byte_index),
    .data_byte   (data_byte),
    .page_select (page_select),
    .read_data   (read_data),
    .status      (status)
  );

endmodule

/* hdl/mpfb_divider.sv */
// Iterative restoring divider: bitmap byte index split into row and byte-in-row.
module mpfb_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mpfb_pkg::IDX_W-1:0] dividend,
  input  logic [mpfb_pkg::WB_W-1:0]  divisor,
  output logic [mpfb_pkg::IDX_W-1:0] quotient,
  output logic [mpfb_pkg::WB_W-1:0]  remainder,
  output logic                       done
);

  logic                           busy;
  logic [mpfb_pkg::DIV_CNT_W-1:0] cnt;
  logic [mpfb_pkg::WB_W-1:0]      dvsr;
  logic [mpfb_pkg::WB_W:0]        partial;
  logic                           fits;

  // One quotient bit per cycle
  assign partial = {remainder, quotient[mpfb_pkg::IDX_W-1]};
  assign fits    = (partial >= {1'b0, dvsr});

  // Sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == mpfb_pkg::DIV_CNT_W'(mpfb_pkg::IDX_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift/subtract datapath
  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      dvsr      <= divisor;
    end else if (busy) begin
      if (fits) begin
        remainder <= mpfb_pkg::WB_W'(partial - {1'b0, dvsr});
      end else begin
        remainder <= partial[mpfb_pkg::WB_W-1:0];
      end
      quotient <= {quotient[mpfb_pkg::IDX_W-2:0], fits};
    end
  end

endmodule

/* hdl/mpfb_datapath.sv */
// Datapath: operand registers, bounds check, address generation and the frame memory.
module mpfb_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  mpfb_pkg::cmd_t               cmd,
  output mpfb_pkg::stat_t              stat,
  input  logic [mpfb_pkg::OP_W-1:0]    operation,
  input  logic [mpfb_pkg::COORD_W-1:0] column,
  input  logic [mpfb_pkg::COORD_W-1:0] row,
  input  logic                         pixel_value,
  input  logic [mpfb_pkg::WB_W-1:0]    width_bytes,
  input  logic [mpfb_pkg::HR_W-1:0]    height_rows,
  input  logic [mpfb_pkg::IDX_W-1:0]   byte_index,
  input  logic [mpfb_pkg::BYTE_W-1:0]  data_byte,
  input  logic [mpfb_pkg::PSEL_W-1:0]  page_select,
  output logic [mpfb_pkg::BYTE_W-1:0]  read_data,
  output logic                         status
);

  // Latched beat
  mpfb_pkg::op_t                op_r;
  logic [mpfb_pkg::COORD_W-1:0] col_r;
  logic [mpfb_pkg::COORD_W-1:0] row_r;
  logic                         pv_r;
  logic [mpfb_pkg::WB_W-1:0]    wb_r;
  logic [mpfb_pkg::HR_W-1:0]    hr_r;
  logic [mpfb_pkg::IDX_W-1:0]   idx_r;
  logic [mpfb_pkg::BYTE_W-1:0]  data_r;
  logic [mpfb_pkg::PSEL_W-1:0]  psel_r;

  logic                         reject_r;
  logic                         reject_c;
  logic [mpfb_pkg::ADDR_W-1:0]  base_r;
  logic [mpfb_pkg::BIT_W-1:0]   bit_r;
  logic [mpfb_pkg::BIT_W-1:0]   k;
  logic [mpfb_pkg::BIT_W-1:0]   rd_k;
  logic [mpfb_pkg::ADDR_W-1:0]  sweep;
  logic                         sweep_last;

  logic [mpfb_pkg::IDX_W-1:0]   div_quo;
  logic [mpfb_pkg::WB_W-1:0]    div_rem;
  logic                         div_done;

  logic [mpfb_pkg::CHK_W-1:0]   col_e, row_e, wb_e, hr_e, idx_e, psel_e;
  logic [mpfb_pkg::CHK_W-1:0]   area, x_end, y_end;
  logic [mpfb_pkg::CHK_W-1:0]   x_e, y_e, page_e, base_e;

  logic [mpfb_pkg::BYTE_W-1:0]  mem [mpfb_pkg::STORE_BYTES];
  logic [mpfb_pkg::BYTE_W-1:0]  mem_q;
  logic [mpfb_pkg::ADDR_W-1:0]  wr_addr;
  logic [mpfb_pkg::ADDR_W-1:0]  rd_addr;
  logic [mpfb_pkg::BYTE_W-1:0]  wr_data;
  logic [mpfb_pkg::BYTE_W-1:0]  mask;
  logic                         bitval;
  logic                         wr_en;

  // Capture the command beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= mpfb_pkg::op_t'(operation);
      col_r  <= column;
      row_r  <= row;
      pv_r   <= pixel_value;
      wb_r   <= width_bytes;
      hr_r   <= height_rows;
      idx_r  <= byte_index;
      data_r <= data_byte;
      psel_r <= page_select;
    end
  end

  // Widened operands
  assign col_e  = mpfb_pkg::CHK_W'(col_r);
  assign row_e  = mpfb_pkg::CHK_W'(row_r);
  assign wb_e   = mpfb_pkg::CHK_W'(wb_r);
  assign hr_e   = mpfb_pkg::CHK_W'(hr_r);
  assign idx_e  = mpfb_pkg::CHK_W'(idx_r);
  assign psel_e = mpfb_pkg::CHK_W'(psel_r);
  assign area   = wb_e * hr_e;
  assign x_end  = col_e + (wb_e << 3);
  assign y_end  = row_e + hr_e;

  // Bounds check; a bitmap is checked as a whole rectangle
  always_comb begin
    unique case (op_r)
      mpfb_pkg::OP_CLEAR: reject_c = 1'b0;
      mpfb_pkg::OP_PIXEL: reject_c = (col_e >= mpfb_pkg::CHK_W'(mpfb_pkg::COLUMNS)) ||
                                     (row_e >= mpfb_pkg::CHK_W'(mpfb_pkg::HEIGHT));
      mpfb_pkg::OP_BLIT:  reject_c = (wb_r == '0) || (hr_r == '0) ||
                                     (x_end > mpfb_pkg::CHK_W'(mpfb_pkg::COLUMNS)) ||
                                     (y_end > mpfb_pkg::CHK_W'(mpfb_pkg::HEIGHT)) ||
                                     (idx_e >= area);
      mpfb_pkg::OP_READ:  reject_c = (col_e >= mpfb_pkg::CHK_W'(mpfb_pkg::COLUMNS)) ||
                                     (psel_e >= mpfb_pkg::CHK_W'(mpfb_pkg::PAGES));
      default:            reject_c = 1'b1;
    endcase
  end

  // Index to (row, byte-in-row) of the bitmap
  mpfb_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (idx_r),
    .divisor   (wb_r),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  // First byte address and bit position
  always_comb begin
    x_e    = col_e;
    y_e    = row_e;
    if (op_r == mpfb_pkg::OP_BLIT) begin
      x_e = col_e + (mpfb_pkg::CHK_W'(div_rem) << 3);
      y_e = row_e + mpfb_pkg::CHK_W'(div_quo);
    end
    page_e = (op_r == mpfb_pkg::OP_READ) ? psel_e : (y_e >> 3);
    base_e = page_e * mpfb_pkg::CHK_W'(mpfb_pkg::COLUMNS) + x_e;
  end

  always_ff @(posedge clk) begin
    if (cmd.base_load) begin
      base_r <= base_e[mpfb_pkg::ADDR_W-1:0];
      bit_r  <= y_e[mpfb_pkg::BIT_W-1:0];
    end
  end

  // Control counters and result flag
  assign sweep_last = (sweep == mpfb_pkg::ADDR_W'(mpfb_pkg::STORE_BYTES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep    <= '0;
      k        <= '0;
      reject_r <= 1'b0;
    end else begin
      if (cmd.load || (cmd.clr_wr && sweep_last)) begin
        sweep <= '0;
      end else if (cmd.clr_wr) begin
        sweep <= sweep + 1'b1;
      end
      if (cmd.base_load) begin
        k <= '0;
      end else if (cmd.k_inc) begin
        k <= k + 1'b1;
      end
      if (cmd.check) begin
        reject_r <= reject_c;
      end
    end
  end

  // Read-modify-write of one byte per cycle; the next column is read alongside
  assign rd_k    = cmd.rd_next ? (k + 1'b1) : k;
  assign rd_addr = base_r + mpfb_pkg::ADDR_W'(rd_k);
  assign mask    = mpfb_pkg::BYTE_W'(1) << bit_r;
  assign bitval  = (op_r == mpfb_pkg::OP_BLIT) ? data_r[k] : pv_r;
  assign wr_en   = cmd.clr_wr || cmd.rmw_wr;
  assign wr_addr = cmd.clr_wr ? sweep : (base_r + mpfb_pkg::ADDR_W'(k));
  assign wr_data = cmd.clr_wr ? '0 : ((mem_q & ~mask) | (bitval ? mask : '0));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Status to the controller
  assign stat.op         = op_r;
  assign stat.reject     = reject_c;
  assign stat.div_done   = div_done;
  assign stat.sweep_last = sweep_last;
  assign stat.rmw_last   = (op_r != mpfb_pkg::OP_BLIT) ||
                           (k == mpfb_pkg::BIT_W'(mpfb_pkg::BYTE_W - 1));

  // Result beat
  assign read_data = ((op_r == mpfb_pkg::OP_READ) && !reject_r) ? mem_q : '0;
  assign status    = reject_r;

endmodule

/* hdl/mpfb_ctrl.sv */
// Controller state machine sequencing clear, pixel, blit and read operations.
module mpfb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  mpfb_pkg::stat_t stat,
  output mpfb_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_CLEAR = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_READ  = 8'b0010_0000,
    S_RMW   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT: begin
        cmd.clr_wr = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        priority if (stat.op == mpfb_pkg::OP_CLEAR) begin
          state_next = S_CLEAR;
        end else if (stat.reject) begin
          state_next = S_DONE;
        end else if (stat.op == mpfb_pkg::OP_BLIT) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.base_load = 1'b1;
          state_next    = S_READ;
        end
      end
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.sweep_last) state_next = S_DONE;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.base_load = 1'b1;
          state_next    = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = (stat.op == mpfb_pkg::OP_READ) ? S_DONE : S_RMW;
      end
      S_RMW: begin
        cmd.rmw_wr = 1'b1;
        cmd.k_inc  = 1'b1;
        if (stat.rmw_last) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

/* tb/mpfb_checker.sv */
// Checker for the page frame store: keeps its own copy of the store and compares every done beat.
`timescale 1ns / 1ps

module mpfb_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         done,
  input  logic [mpfb_pkg::OP_W-1:0]    operation,
  input  logic [mpfb_pkg::COORD_W-1:0] column,
  input  logic [mpfb_pkg::COORD_W-1:0] row,
  input  logic                         pixel_value,
  input  logic [mpfb_pkg::WB_W-1:0]    width_bytes,
  input  logic [mpfb_pkg::HR_W-1:0]    height_rows,
  input  logic [mpfb_pkg::IDX_W-1:0]   byte_index,
  input  logic [mpfb_pkg::BYTE_W-1:0]  data_byte,
  input  logic [mpfb_pkg::PSEL_W-1:0]  page_select,
  input  logic [mpfb_pkg::BYTE_W-1:0]  read_data,
  input  logic                         status,
  output int                           fail_count,
  output int                           pending
);

  typedef struct packed {
    logic [mpfb_pkg::BYTE_W-1:0] read_data;
    logic                        status;
  } frame_result_t;

  logic [mpfb_pkg::BYTE_W-1:0] frame_store [0:mpfb_pkg::STORE_BYTES-1];
  frame_result_t               awaited_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // one pixel into the shadow store, bit (y mod 8) of page y/8
  function automatic void plot_pixel(int x, int y, logic v);
    int addr;
    if (x >= mpfb_pkg::COLUMNS || y >= mpfb_pkg::HEIGHT) return;
    addr = (y / 8) * mpfb_pkg::COLUMNS + x;
    frame_store[addr][y % 8] = v;
  endfunction

  // apply one command to the shadow store and return what the block should report
  function automatic frame_result_t apply_command(
    mpfb_pkg::op_t op, int col, int y0, logic pv, int wb, int hr, int idx,
    logic [mpfb_pkg::BYTE_W-1:0] bits, int page);
    frame_result_t res;
    int x0;
    int y;
    res = '0;
    case (op)
      mpfb_pkg::OP_CLEAR: begin
        for (int a = 0; a < mpfb_pkg::STORE_BYTES; a++) frame_store[a] = '0;
      end
      mpfb_pkg::OP_PIXEL: begin
        if (col >= mpfb_pkg::COLUMNS || y0 >= mpfb_pkg::HEIGHT) res.status = 1'b1;
        else plot_pixel(col, y0, pv);
      end
      mpfb_pkg::OP_BLIT: begin
        // whole rectangle checked before anything is written
        if (wb == 0 || hr == 0 || col + wb * 8 > mpfb_pkg::COLUMNS ||
            y0 + hr > mpfb_pkg::HEIGHT || idx >= wb * hr) begin
          res.status = 1'b1;
        end else begin
          x0 = col + (idx % wb) * 8;
          y  = y0 + idx / wb;
          for (int k = 0; k < 8; k++) plot_pixel(x0 + k, y, bits[k]);
        end
      end
      default: begin
        if (col >= mpfb_pkg::COLUMNS || page >= mpfb_pkg::PAGES) res.status = 1'b1;
        else res.read_data = frame_store[page * mpfb_pkg::COLUMNS + col];
      end
    endcase
    return res;
  endfunction

  // results are compared before the beat of the same edge is predicted
  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      awaited_results.delete();
      for (int a = 0; a < mpfb_pkg::STORE_BYTES; a++) frame_store[a] = '0;
    end else begin
      if (done) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: read_data %0h status %0b", read_data, status);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, read_data);
            fail_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, status);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        awaited_results.push_back(apply_command(mpfb_pkg::op_t'(operation), int'(column),
                                                int'(row), pixel_value, int'(width_bytes),
                                                int'(height_rows), int'(byte_index),
                                                data_byte, int'(page_select)));
      end
    end
    pending <= awaited_results.size();
  end

endmodule

/* tb/tb_mono_page_framebuffer_blit_unit.sv */
// Testbench top: drives directed and random drawing commands and reports the verdict.
`timescale 1ns / 1ps

module tb_mono_page_framebuffer_blit_unit;

  localparam int CYCLE_LIMIT  = 4000000;
  localparam int PHASE_BEATS  = 435;
  localparam int DRAIN_CYCLES = 30;

  typedef struct {
    mpfb_pkg::op_t                op;
    logic [mpfb_pkg::COORD_W-1:0] column;
    logic [mpfb_pkg::COORD_W-1:0] row;
    logic                         pixel_value;
    logic [mpfb_pkg::WB_W-1:0]    width_bytes;
    logic [mpfb_pkg::HR_W-1:0]    height_rows;
    logic [mpfb_pkg::IDX_W-1:0]   byte_index;
    logic [mpfb_pkg::BYTE_W-1:0]  data_byte;
    logic [mpfb_pkg::PSEL_W-1:0]  page_select;
  } draw_cmd_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic [mpfb_pkg::OP_W-1:0]    operation = '0;
  logic [mpfb_pkg::COORD_W-1:0] column = '0;
  logic [mpfb_pkg::COORD_W-1:0] row = '0;
  logic                         pixel_value = 1'b0;
  logic [mpfb_pkg::WB_W-1:0]    width_bytes = '0;
  logic [mpfb_pkg::HR_W-1:0]    height_rows = '0;
  logic [mpfb_pkg::IDX_W-1:0]   byte_index = '0;
  logic [mpfb_pkg::BYTE_W-1:0]  data_byte = '0;
  logic [mpfb_pkg::PSEL_W-1:0]  page_select = '0;
  logic                         busy;
  logic                         done;
  logic [mpfb_pkg::BYTE_W-1:0]  read_data;
  logic                         status;
  int                           fail_count;
  int                           pending;
  int                           cycle_count = 0;

  // current bitmap being streamed byte by byte
  int bm_col, bm_row, bm_wb, bm_hr, bm_next;

  mono_page_framebuffer_blit_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .operation(operation), .column(column), .row(row), .pixel_value(pixel_value),
    .width_bytes(width_bytes), .height_rows(height_rows), .byte_index(byte_index),
    .data_byte(data_byte), .page_select(page_select),
    .read_data(read_data), .status(status)
  );

  mpfb_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .operation(operation), .column(column), .row(row), .pixel_value(pixel_value),
    .width_bytes(width_bytes), .height_rows(height_rows), .byte_index(byte_index),
    .data_byte(data_byte), .page_select(page_select),
    .read_data(read_data), .status(status),
    .fail_count(fail_count), .pending(pending)
  );

  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // present one beat and hold it until the block takes it
  task automatic send_beat(input draw_cmd_t c);
    start       <= 1'b1;
    operation   <= c.op;
    column      <= c.column;
    row         <= c.row;
    pixel_value <= c.pixel_value;
    width_bytes <= c.width_bytes;
    height_rows <= c.height_rows;
    byte_index  <= c.byte_index;
    data_byte   <= c.data_byte;
    page_select <= c.page_select;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_fields(input mpfb_pkg::op_t op, input int col, input int y, input int pv,
                             input int wb, input int hr, input int idx, input int bits,
                             input int page);
    draw_cmd_t c;
    c.op          = op;
    c.column      = mpfb_pkg::COORD_W'(col);
    c.row         = mpfb_pkg::COORD_W'(y);
    c.pixel_value = 1'(pv);
    c.width_bytes = mpfb_pkg::WB_W'(wb);
    c.height_rows = mpfb_pkg::HR_W'(hr);
    c.byte_index  = mpfb_pkg::IDX_W'(idx);
    c.data_byte   = mpfb_pkg::BYTE_W'(bits);
    c.page_select = mpfb_pkg::PSEL_W'(page);
    send_beat(c);
  endtask

  // wait until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // mostly small bitmaps, now and then wider or taller ones up to the full width or height
  task automatic pick_bitmap();
    bm_wb   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 3);
    bm_hr   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 6);
    bm_col  = $urandom_range(0, mpfb_pkg::COLUMNS - bm_wb * 8);
    bm_row  = $urandom_range(0, mpfb_pkg::HEIGHT - bm_hr);
    bm_next = 0;
  endtask

  // every field random first, then shaped by the kind of beat
  task automatic make_random_cmd(output draw_cmd_t c);
    int pick;
    int area;
    c.op          = mpfb_pkg::op_t'($urandom_range(1, 3));
    c.column      = mpfb_pkg::COORD_W'($urandom);
    c.row         = mpfb_pkg::COORD_W'($urandom);
    c.pixel_value = 1'($urandom);
    c.width_bytes = mpfb_pkg::WB_W'($urandom);
    c.height_rows = mpfb_pkg::HR_W'($urandom);
    c.byte_index  = mpfb_pkg::IDX_W'($urandom);
    c.data_byte   = mpfb_pkg::BYTE_W'($urandom);
    c.page_select = mpfb_pkg::PSEL_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      c.op = mpfb_pkg::OP_CLEAR;
    end else if (pick < 45) begin
      // next byte of the current bitmap, occasionally out of order or past its end
      if (bm_next >= bm_wb * bm_hr || $urandom_range(0, 29) == 0) pick_bitmap();
      area          = bm_wb * bm_hr;
      c.op          = mpfb_pkg::OP_BLIT;
      c.column      = mpfb_pkg::COORD_W'(bm_col);
      c.row         = mpfb_pkg::COORD_W'(bm_row);
      c.width_bytes = mpfb_pkg::WB_W'(bm_wb);
      c.height_rows = mpfb_pkg::HR_W'(bm_hr);
      if ($urandom_range(0, 9) == 0 && area <= 1023) begin
        c.byte_index = mpfb_pkg::IDX_W'($urandom_range(area, 1023));
      end else if ($urandom_range(0, 3) == 0) begin
        c.byte_index = mpfb_pkg::IDX_W'($urandom_range(0, area - 1));
      end else begin
        c.byte_index = mpfb_pkg::IDX_W'(bm_next);
        bm_next++;
      end
    end else if (pick < 70) begin
      c.op = mpfb_pkg::OP_READ;
      if ($urandom_range(0, 1) == 0) begin
        // read back inside the bitmap just drawn
        c.column      = mpfb_pkg::COORD_W'(bm_col + $urandom_range(0, bm_wb * 8 - 1));
        c.page_select = mpfb_pkg::PSEL_W'((bm_row + $urandom_range(0, bm_hr - 1)) / 8);
      end else if ($urandom_range(0, 7) != 0) begin
        c.column = mpfb_pkg::COORD_W'($urandom_range(0, mpfb_pkg::COLUMNS - 1));
      end
    end else if (pick < 88) begin
      c.op = mpfb_pkg::OP_PIXEL;
      if ($urandom_range(0, 7) != 0) begin
        c.column = mpfb_pkg::COORD_W'($urandom_range(0, mpfb_pkg::COLUMNS - 1));
        c.row    = mpfb_pkg::COORD_W'($urandom_range(0, mpfb_pkg::HEIGHT - 1));
      end
    end
  endtask

  initial begin
    draw_cmd_t  c;
    int         idle_pct [3];
    idle_pct = '{0, 61, 35};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, each operation and every rejection
    send_fields(mpfb_pkg::OP_READ,    0,   0, 0,  1,   1,    0, 8'h00, 0);
    send_fields(mpfb_pkg::OP_PIXEL,   0,   0, 1,  1,   1,    0, 8'h00, 0);
    send_fields(mpfb_pkg::OP_PIXEL, 127,  63, 1,  1,   1,    0, 8'h00, 0);
    send_fields(mpfb_pkg::OP_PIXEL, 128,   0, 1,  1,   1,    0, 8'h00, 0);
    send_fields(mpfb_pkg::OP_PIXEL,   0,  64, 1,  1,   1,    0, 8'h00, 0);
    send_fields(mpfb_pkg::OP_PIXEL, 255, 255, 1, 31, 127, 1023, 8'hFF, 7);
    send_fields(mpfb_pkg::OP_READ,    0,   0, 0,  0,   0,    0, 8'h00, 0);
    send_fields(mpfb_pkg::OP_READ,  127,   0, 0,  0,   0,    0, 8'h00, 7);
    send_fields(mpfb_pkg::OP_READ,  128,   0, 0,  0,   0,    0, 8'h00, 0);
    send_fields(mpfb_pkg::OP_READ,  255, 255, 1, 31, 127, 1023, 8'hFF, 7);
    // pixel value zero clears
    send_fields(mpfb_pkg::OP_PIXEL,   0,   0, 0,  1,   1,    0, 8'h00, 0);
    send_fields(mpfb_pkg::OP_READ,    0,   0, 0,  0,   0,    0, 8'h00, 0);
    // largest bitmap, last byte lands in the bottom right corner
    send_fields(mpfb_pkg::OP_BLIT,    0,   0, 0, 16,  64, 1023, 8'hFF, 0);
    send_fields(mpfb_pkg::OP_READ,  120,   0, 0,  0,   0,    0, 8'h00, 7);
    send_fields(mpfb_pkg::OP_BLIT,    0,   0, 0,  0,   1,    0, 8'hFF, 0);
    send_fields(mpfb_pkg::OP_BLIT,    0,   0, 0,  1,   0,    0, 8'hFF, 0);
    send_fields(mpfb_pkg::OP_BLIT,    1,   0, 0, 16,   1,    0, 8'hFF, 0);
    send_fields(mpfb_pkg::OP_BLIT,    0,   1, 0,  1,  64,    0, 8'hFF, 0);
    send_fields(mpfb_pkg::OP_BLIT,    0,   0, 0,  2,   3,    6, 8'hFF, 0);
    send_fields(mpfb_pkg::OP_BLIT,    0,   0, 0, 31, 127,    0, 8'hFF, 0);
    send_fields(mpfb_pkg::OP_BLIT,  120,   8, 0,  1,   1,    0, 8'hA5, 0);
    send_fields(mpfb_pkg::OP_READ,  122,   0, 0,  0,   0,    0, 8'h00, 1);
    send_fields(mpfb_pkg::OP_CLEAR,   0,   0, 0,  0,   0,    0, 8'h00, 0);
    send_fields(mpfb_pkg::OP_READ,  127,   0, 0,  0,   0,    0, 8'h00, 7);
    send_fields(mpfb_pkg::OP_BLIT,    0,  56, 0,  1,   8,    7, 8'h5A, 0);
    drain_results();

    // random phases with different sender idling, drained in between
    pick_bitmap();
    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < PHASE_BEATS; n++) begin
        make_random_cmd(c);
        send_beat(c);
        if ($urandom_range(0, 99) < idle_pct[ph]) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/mpfb_pkg.sv
hdl/mpfb_divider.sv
hdl/mpfb_datapath.sv
hdl/mpfb_ctrl.sv
hdl/mono_page_framebuffer_blit_unit.sv
tb/mpfb_checker.sv
tb/tb_mono_page_framebuffer_blit_unit.sv
